[src/lkmp_pkg.sv]
package lkmp_pkg;

	localparam int MAX_PEAKS = 16;
	localparam int MAX_OUT   = 16;
	localparam int ADDR_W    = $clog2(MAX_PEAKS);
	localparam int PC_W      = $clog2(MAX_PEAKS + 1);

	localparam int VAL_W     = 16;
	localparam int IDX_W     = 16;
	localparam int RATIO_W   = 15;
	localparam int MR_W      = 5;
	localparam int ENTRY_W   = VAL_W + IDX_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REP    = 2'd2;

	localparam logic [15:0]        FRAME_LEN_RST  = 16'd2048;
	localparam logic [RATIO_W-1:0] PEAK_RATIO_RST = 15'd29491;
	localparam logic [MR_W-1:0]    MAX_REP_RST    = 5'd16;

	typedef struct packed {
		logic sample_go;
		logic clear_go;
		logic rd_start;
		logic rd_issue;
		logic skip;
		logic push;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic qual;
		logic out_free;
	} sts_t;

endpackage

[src/lkmp_ram.sv]
module lkmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/lkmp_dp.sv]
module lkmp_dp import lkmp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	input  logic signed [VAL_W-1:0]     sample,
	input  logic                        cfg_valid,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic signed [VAL_W-1:0]     peak_value,
	output logic [IDX_W-1:0]            peak_index,
	output logic                        empty_res,
	output logic                        last
);

	typedef enum logic [1:0] {M_SEARCH, M_WALK, M_END} mode_t;

	// configuration
	logic [15:0]        frame_len_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [MR_W-1:0]    max_rep_q;

	// frame state
	mode_t                   mode_q;
	logic [IDX_W-1:0]        count_q;
	logic signed [VAL_W-1:0] prev_q;
	logic signed [VAL_W-1:0] lobe_val_q;
	logic [IDX_W-1:0]        lobe_idx_q;
	logic [PC_W-1:0]         peak_cnt_q;
	logic signed [VAL_W-1:0] gmax_val_q;
	logic [IDX_W-1:0]        gmax_idx_q;

	// readout
	logic signed [31:0]      bar_q;
	logic [PC_W-1:0]         scan_idx_q;
	logic [MR_W-1:0]         n_q;
	logic signed [VAL_W-1:0] pend_val_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic                    pend_empty_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic                    out_empty_q;
	logic                    out_last_q;

	logic                    open_lobe;
	logic                    close_lobe;
	logic                    grow_lobe;
	logic                    frame_end;
	logic                    store_we;
	logic                    take_global;
	logic [ENTRY_W-1:0]      rd_entry;
	logic signed [VAL_W-1:0] rd_val;
	logic [IDX_W-1:0]        rd_idx;
	logic signed [31:0]      rd_scaled;
	logic signed [VAL_W:0]   ratio_s;
	logic [MR_W-1:0]         limit;

	always_comb begin
		open_lobe  = (mode_q == M_SEARCH) && prev_q[VAL_W-1] && !sample[VAL_W-1];
		frame_end  = (mode_q == M_SEARCH) && !open_lobe
			&& ({1'b0, frame_len_q} <= ({1'b0, count_q} + 17'd1));
		close_lobe = (mode_q == M_WALK) && !prev_q[VAL_W-1] && sample[VAL_W-1];
		grow_lobe  = (mode_q == M_WALK) && !close_lobe && (lobe_val_q < sample);
		store_we   = cmd.sample_go && close_lobe && (peak_cnt_q < PC_W'(MAX_PEAKS));
		take_global = (peak_cnt_q == '0) || (gmax_val_q < lobe_val_q);
	end

	lkmp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PEAKS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(peak_cnt_q[ADDR_W-1:0]),
		.wdata({lobe_val_q, lobe_idx_q}),
		.re   (cmd.rd_issue),
		.raddr(scan_idx_q[ADDR_W-1:0]),
		.rdata(rd_entry)
	);

	assign rd_val    = rd_entry[ENTRY_W-1 -: VAL_W];
	assign rd_idx    = rd_entry[IDX_W-1:0];
	assign rd_scaled = {rd_val[VAL_W-1], rd_val, 15'd0};
	assign ratio_s   = {2'b00, ratio_q};

	always_comb begin
		if (max_rep_q == '0) begin
			limit = MR_W'(1);
		end else if (max_rep_q > MR_W'(MAX_OUT)) begin
			limit = MR_W'(MAX_OUT);
		end else begin
			limit = max_rep_q;
		end
	end

	assign sts.scan_done = !((scan_idx_q < peak_cnt_q) && (n_q < limit));
	assign sts.qual      = (rd_scaled >= bar_q) && (rd_idx != gmax_idx_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= FRAME_LEN_RST;
			ratio_q     <= PEAK_RATIO_RST;
			max_rep_q   <= MAX_REP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_LEN:  frame_len_q <= cfg_data;
				REG_PEAK_RATIO: ratio_q     <= cfg_data[RATIO_W-1:0];
				REG_MAX_REP:    max_rep_q   <= cfg_data[MR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_SEARCH;
			count_q    <= '0;
			prev_q     <= '0;
			lobe_val_q <= '0;
			lobe_idx_q <= '0;
			peak_cnt_q <= '0;
			gmax_val_q <= '0;
			gmax_idx_q <= '0;
		end else if (cmd.clear_go) begin
			mode_q     <= M_SEARCH;
			count_q    <= '0;
			prev_q     <= '0;
			lobe_val_q <= '0;
			lobe_idx_q <= '0;
			peak_cnt_q <= '0;
			gmax_val_q <= '0;
			gmax_idx_q <= '0;
		end else if (cmd.sample_go) begin
			prev_q  <= sample;
			count_q <= count_q + IDX_W'(1);
			if (open_lobe) begin
				lobe_val_q <= sample;
				lobe_idx_q <= count_q;
				mode_q     <= M_WALK;
			end else if (frame_end) begin
				mode_q <= M_END;
			end
			if (close_lobe) begin
				mode_q <= M_SEARCH;
			end
			if (grow_lobe) begin
				lobe_val_q <= sample;
				lobe_idx_q <= count_q;
			end
			// a full store drops the lobe and leaves the global maximum alone
			if (store_we) begin
				peak_cnt_q <= peak_cnt_q + PC_W'(1);
				if (take_global) begin
					gmax_val_q <= lobe_val_q;
					gmax_idx_q <= lobe_idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			n_q        <= '0;
		end else if (cmd.rd_start) begin
			scan_idx_q <= '0;
			n_q        <= MR_W'(1);
		end else if (cmd.push) begin
			scan_idx_q <= scan_idx_q + PC_W'(1);
			n_q        <= n_q + MR_W'(1);
		end else if (cmd.skip) begin
			scan_idx_q <= scan_idx_q + PC_W'(1);
		end
	end

	// threshold and pending item, global maximum goes out first
	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			bar_q <= ratio_s * gmax_val_q;
			if (peak_cnt_q == '0) begin
				pend_val_q   <= '0;
				pend_idx_q   <= '0;
				pend_empty_q <= 1'b1;
			end else begin
				pend_val_q   <= gmax_val_q;
				pend_idx_q   <= gmax_idx_q;
				pend_empty_q <= 1'b0;
			end
		end else if (cmd.push) begin
			pend_val_q   <= rd_val;
			pend_idx_q   <= rd_idx;
			pend_empty_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.flush) begin
			out_val_q   <= pend_val_q;
			out_idx_q   <= pend_idx_q;
			out_empty_q <= pend_empty_q;
			out_last_q  <= cmd.flush;
		end
	end

	assign out_valid  = out_valid_q;
	assign peak_value = out_val_q;
	assign peak_index = out_idx_q;
	assign empty_res  = out_empty_q;
	assign last       = out_last_q;

endmodule

[src/lkmp_ctrl.sv]
module lkmp_ctrl import lkmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FLUSH} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (action)
						ACT_SAMPLE: cmd.sample_go = 1'b1;
						ACT_CLEAR:  cmd.clear_go  = 1'b1;
						ACT_READ: begin
							cmd.rd_start = 1'b1;
							state_d      = S_READ;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				if (sts.scan_done) begin
					state_d = S_FLUSH;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = S_EVAL;
				end
			end
			S_EVAL: begin
				// pending item leaves only once a later one is known to follow
				if (!sts.qual) begin
					cmd.skip = 1'b1;
					state_d  = S_READ;
				end else if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_READ;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/lobe_key_maximum_picker_unit.sv]
// Sample and clear items are accepted on consecutive cycles while no readout runs.
// Readout: each scanned lobe takes a registered store read, then a compare;
// each result waits while the output register is still occupied.
// Empty store: the single result passes through S_READ and S_FLUSH to the output register.
// Reset restores register defaults and clears frame state; store is not swept.
module lobe_key_maximum_picker_unit import lkmp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic signed [VAL_W-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] peak_value,
	output logic [IDX_W-1:0]        peak_index,
	output logic                    empty_res,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lkmp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action  (action),
		.sts     (sts),
		.cmd     (cmd)
	);

	lkmp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.peak_value(peak_value),
		.peak_index(peak_index),
		.empty_res (empty_res),
		.last      (last)
	);

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.flush) |-> sts.out_free)
		else $error("result loaded while output register still held");

	a_push_qual: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.qual)
		else $error("non-qualifying entry pushed");

	a_no_sample_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_issue || cmd.push || cmd.skip || cmd.flush)
		|-> !(cmd.sample_go || cmd.clear_go))
		else $error("frame state touched during readout");

	a_last_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (out_valid && last))
		else $error("final readout item not presented");
`endif

endmodule
